// ===== src/chad_pkg.sv =====
// Shared types and constants for the canonical Huffman archive decoder.
package chad_pkg;

	typedef enum logic [2:0] {
		PH_COUNT   = 3'd0,
		PH_SYMBOLS = 3'd1,
		PH_LENGTHS = 3'd2,
		PH_NAME    = 3'd3,
		PH_DATA    = 3'd4,
		PH_ERROR   = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	localparam logic [2:0] EV_NAME_BYTE = 3'd0;
	localparam logic [2:0] EV_NAME_END  = 3'd1;
	localparam logic [2:0] EV_DATA_BYTE = 3'd2;
	localparam logic [2:0] EV_FILE_MORE = 3'd3;
	localparam logic [2:0] EV_ARCH_END  = 3'd4;
	localparam logic [2:0] EV_ERROR     = 3'd5;

	localparam int FIELD_BITS = 9;

	localparam logic [1:0] REG_NAME_END = 2'd0;
	localparam logic [1:0] REG_MORE     = 2'd1;
	localparam logic [1:0] REG_ARCH_END = 2'd2;

endpackage

// ===== src/canonical_huffman_archive_decoder_unit.sv =====
// Decoder for a bit-serial archive of files coded with canonical Huffman tables.
// Header bits are taken one per cycle, back to back. Code bits are taken one per
// cycle too, except that the input holds after the final bit of a code while the
// symbol is read. The input also holds while an event word waits unaccepted in
// the one-word output register. Each input word yields at most one event word.
// The symbol table and the per-length count table sit in synchronous RAMs. The
// count for the code length the next bit will reach is read ahead into a
// register; a write to the count table is forwarded over the read. An error
// event leaves in the cycle after its word is taken; a decoded symbol's event
// first passes the registered symbol read and the lookup flag lk_pend_q.
// After a format error or archive end the block drops all input until reset.
module canonical_huffman_archive_decoder_unit #(
	parameter int MAX_SYMBOLS  = 512,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [0] in_bit, [1] end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [15:0] m_tdata,  // [2:0] event_kind, [10:3] byte_value
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);
	localparam int SW = $clog2(MAX_SYMBOLS + 1);
	localparam int AW = $clog2(MAX_SYMBOLS);
	localparam int LW = $clog2(MAX_CODE_LEN + 1);
	localparam int CW = $clog2(MAX_CODE_LEN);
	localparam int VW = (MAX_CODE_LEN + 1 > 64) ? 64 : MAX_CODE_LEN + 1;

	logic [8:0] sym_mem [MAX_SYMBOLS];
	logic [8:0] len_mem [MAX_CODE_LEN];

	logic [8:0] name_end_q, more_q, arch_end_q;
	chad_pkg::phase_t phase_q;
	logic [8:0] shift_q;
	logic [3:0] fcnt_q;
	logic [SW-1:0] total_q, loaded_q, unasg_q;
	logic [LW-1:0] last_q, clen_q;
	logic [VW-1:0] code_q, first_q;
	logic [SW:0] base_q;
	logic [8:0] cnt_rd_q;      // len_mem[clen_q] (next length's count)
	logic [8:0] sym_rd_q;
	logic lk_pend_q;           // a symbol lookup completes this cycle
	logic m_valid_q;
	logic [2:0] m_kind_q;
	logic [7:0] m_byte_q;

	// Stall whole input while output holds, as a new event could collide, or while a symbol lookup completes.
	logic out_free;
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = out_free && !lk_pend_q;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_valid_q;
	assign m_tdata = {5'd0, m_byte_q, m_kind_q};

	logic acc, bitv, eoi;
	assign acc = s_tvalid && s_tready;
	assign bitv = s_tdata[0];
	assign eoi = s_tdata[1];

	// Header field assembly.
	logic [8:0] fld;
	logic fdone;
	assign fld = {shift_q[7:0], bitv};
	assign fdone = (fcnt_q == 4'(chad_pkg::FIELD_BITS - 1));

	// Decode arithmetic for one code bit.
	logic [VW-1:0] cv, diff;
	logic [LW-1:0] cl;
	logic hit, too_long;
	assign cv = {code_q[VW-2:0], bitv};
	assign cl = clen_q + LW'(1);
	assign diff = cv - first_q;
	assign too_long = (cl > last_q);
	assign hit = (diff < VW'(cnt_rd_q));

	logic [SW:0] idx;
	assign idx = base_q + (SW+1)'(diff);

	// Next-state control, registered below.
	logic ev_v;
	logic [2:0] ev_k;
	logic lk_go;
	logic len_we;
	logic [LW-1:0] next_clen;

	always_comb begin
		ev_v = 1'b0;
		ev_k = chad_pkg::EV_ERROR;
		lk_go = 1'b0;
		len_we = 1'b0;
		if (acc && phase_q != chad_pkg::PH_ERROR && phase_q != chad_pkg::PH_DONE) begin
			if (eoi) begin
				ev_v = 1'b1;
			end else if (phase_q == chad_pkg::PH_COUNT) begin
				if (fdone && SW'(fld) > SW'(MAX_SYMBOLS)) ev_v = 1'b1;
			end else if (phase_q == chad_pkg::PH_LENGTHS) begin
				if (fdone) begin
					if (SW'(fld) > unasg_q || last_q >= LW'(MAX_CODE_LEN)) ev_v = 1'b1;
					else begin
						len_we = 1'b1;
						if (unasg_q != SW'(fld) && last_q + LW'(1) >= LW'(MAX_CODE_LEN))
							ev_v = 1'b1;
					end
				end
			end else if (phase_q == chad_pkg::PH_SYMBOLS) begin
				ev_v = 1'b0;
			end else begin
				if (too_long || cl > LW'(MAX_CODE_LEN)) ev_v = 1'b1;
				else if (hit) lk_go = 1'b1;
				else if (cl >= last_q) ev_v = 1'b1;
			end
		end
	end

	// Length the decoder sits at after this cycle; prefetch its count.
	always_comb begin
		next_clen = clen_q;
		if (acc && !eoi && (phase_q == chad_pkg::PH_NAME || phase_q == chad_pkg::PH_DATA)
				&& !ev_v)
			next_clen = lk_go ? LW'(0) : cl;
		else if (acc && !eoi && phase_q == chad_pkg::PH_COUNT && fdone)
			next_clen = LW'(0);
	end

	logic [CW-1:0] len_ra, len_wa;
	assign len_ra = next_clen[CW-1:0];
	assign len_wa = last_q[CW-1:0];

	always_ff @(posedge clk) begin
		if (len_we) len_mem[len_wa] <= fld;
		if (len_we && len_wa == len_ra) cnt_rd_q <= fld;
		else cnt_rd_q <= len_mem[len_ra];
	end

	always_ff @(posedge clk) begin
		if (acc && !eoi && phase_q == chad_pkg::PH_SYMBOLS && fdone
				&& loaded_q < SW'(MAX_SYMBOLS))
			sym_mem[loaded_q[AW-1:0]] <= fld;
		if (idx < (SW+1)'(MAX_SYMBOLS)) sym_rd_q <= sym_mem[idx[AW-1:0]];
		else sym_rd_q <= 9'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_end_q <= 9'd256;
			more_q <= 9'd257;
			arch_end_q <= 9'd258;
		end else if (cfg_valid) begin
			case (cfg_index)
				chad_pkg::REG_NAME_END: name_end_q <= cfg_data;
				chad_pkg::REG_MORE:     more_q <= cfg_data;
				chad_pkg::REG_ARCH_END: arch_end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= chad_pkg::PH_COUNT;
			shift_q <= '0;
			fcnt_q <= '0;
			total_q <= '0;
			loaded_q <= '0;
			unasg_q <= '0;
			last_q <= '0;
			clen_q <= '0;
			code_q <= '0;
			first_q <= '0;
			base_q <= '0;
			lk_pend_q <= 1'b0;
			m_valid_q <= 1'b0;
			m_kind_q <= '0;
			m_byte_q <= '0;
		end else begin
			if (ev_v || lk_pend_q) m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			lk_pend_q <= lk_go;
			clen_q <= next_clen;
			if (ev_v) begin
				phase_q <= chad_pkg::PH_ERROR;
				m_kind_q <= ev_k;
				m_byte_q <= '0;
			end
			// Resolve a looked-up symbol.
			if (lk_pend_q) begin
				if (phase_q == chad_pkg::PH_NAME) begin
					if (sym_rd_q == name_end_q) begin
						phase_q <= chad_pkg::PH_DATA;
						m_kind_q <= chad_pkg::EV_NAME_END;
						m_byte_q <= '0;
					end else begin
						m_kind_q <= chad_pkg::EV_NAME_BYTE;
						m_byte_q <= sym_rd_q[7:0];
					end
				end else if (sym_rd_q == arch_end_q) begin
					phase_q <= chad_pkg::PH_DONE;
					m_kind_q <= chad_pkg::EV_ARCH_END;
					m_byte_q <= '0;
				end else if (sym_rd_q == more_q) begin
					phase_q <= chad_pkg::PH_COUNT;
					shift_q <= '0;
					fcnt_q <= '0;
					m_kind_q <= chad_pkg::EV_FILE_MORE;
					m_byte_q <= '0;
				end else begin
					m_kind_q <= chad_pkg::EV_DATA_BYTE;
					m_byte_q <= sym_rd_q[7:0];
				end
			end
			if (acc && !eoi && !ev_v) begin
				unique case (phase_q)
					chad_pkg::PH_COUNT, chad_pkg::PH_SYMBOLS, chad_pkg::PH_LENGTHS: begin
						shift_q <= fdone ? 9'd0 : fld;
						fcnt_q <= fdone ? 4'd0 : fcnt_q + 4'd1;
						if (fdone) begin
							if (phase_q == chad_pkg::PH_COUNT) begin
								total_q <= SW'(fld);
								unasg_q <= SW'(fld);
								loaded_q <= '0;
								last_q <= '0;
								code_q <= '0;
								first_q <= '0;
								base_q <= '0;
								phase_q <= (fld == 9'd0) ? chad_pkg::PH_NAME
									: chad_pkg::PH_SYMBOLS;
							end else if (phase_q == chad_pkg::PH_SYMBOLS) begin
								loaded_q <= loaded_q + SW'(1);
								if (loaded_q + SW'(1) >= total_q)
									phase_q <= chad_pkg::PH_LENGTHS;
							end else begin
								last_q <= last_q + LW'(1);
								unasg_q <= unasg_q - SW'(fld);
								if (unasg_q == SW'(fld)) begin
									code_q <= '0;
									first_q <= '0;
									base_q <= '0;
									phase_q <= chad_pkg::PH_NAME;
								end
							end
						end
					end
					chad_pkg::PH_NAME, chad_pkg::PH_DATA: begin
						if (lk_go) begin
							code_q <= '0;
							first_q <= '0;
							base_q <= '0;
						end else begin
							code_q <= cv;
							base_q <= base_q + (SW+1)'(cnt_rd_q);
							first_q <= (first_q + VW'(cnt_rd_q)) << 1;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== src/chad_checker.sv =====
// Port-level checker for the archive decoder, bound to the decoder module.
module chad_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [15:0] m_tdata
);
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= chad_pkg::EV_ERROR)
		else $error("bad event kind");
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != chad_pkg::EV_NAME_BYTE
			&& m_tdata[2:0] != chad_pkg::EV_DATA_BYTE |-> m_tdata[10:3] == 8'd0)
		else $error("byte set on control event");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word dropped");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:11] == 5'd0)
		else $error("pad bits set");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tvalid |-> m_tready)
		else $error("input word taken while output word held");
endmodule

bind canonical_huffman_archive_decoder_unit chad_checker u_chad_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
